### sv/premultiplied_alpha_converter_top_defines.svh
// Assertion macros for the premultiplied alpha converter.
`ifndef PREMULTIPLIED_ALPHA_CONVERTER_TOP_DEFINES_SVH
`define PREMULTIPLIED_ALPHA_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PAC_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("premultiplied alpha converter: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PAC_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("premultiplied alpha converter: next-cycle check failed");

`endif

### sv/pac_pkg.sv
package pac_pkg;

    localparam int CHANNEL_BITS_DEFAULT = 8;
    localparam int LANES                = 3;   // red, green, blue
    localparam int CFG_INDEX_BITS       = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HAS_ALPHA = 1'b1;

    typedef struct packed {
        logic direction;   // 0 forward, 1 reverse
        logic has_alpha;
    } pac_cfg_t;

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;        // reverse with zero alpha: force black
    } pac_ctl_t;

endpackage

### sv/pac_cfg_regs.sv
module pac_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pac_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic                                 cfg_data,
    output pac_pkg::pac_cfg_t                    cfg
);
    import pac_pkg::*;

    pac_cfg_t cfg_reg;
    pac_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DIRECTION: cfg_next.direction = cfg_data;
                REG_HAS_ALPHA: cfg_next.has_alpha = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction <= 1'b0;
            cfg_reg.has_alpha <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/pac_front.sv
// Two stages: scale product, then numerator / divisor and overflow check.
module pac_front #(
    parameter int CHANNEL_BITS = pac_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           accept,
    input  pac_pkg::pac_cfg_t                              cfg,
    input  logic [pac_pkg::LANES-1:0][CHANNEL_BITS-1:0]    colour,
    input  logic [CHANNEL_BITS-1:0]                        alpha,
    output pac_pkg::pac_ctl_t                              ctl_out,
    output logic [pac_pkg::LANES-1:0]                      sat_out,
    output logic [CHANNEL_BITS-1:0]                        alpha_out,
    output logic [CHANNEL_BITS:0]                          div_out,
    output logic [pac_pkg::LANES-1:0][2*CHANNEL_BITS:0]    num_out
);
    import pac_pkg::*;

    localparam int PW = 2 * CHANNEL_BITS;
    localparam int NW = 2 * CHANNEL_BITS + 1;
    localparam logic [CHANNEL_BITS-1:0] CMAX = {CHANNEL_BITS{1'b1}};

    // stage 0
    logic                               valid0_reg;
    logic [LANES-1:0][PW-1:0]           prod_reg;
    logic [LANES-1:0][PW-1:0]           prod_next;
    logic [CHANNEL_BITS-1:0]            scale_reg;
    logic [CHANNEL_BITS-1:0]            scale_next;
    logic [CHANNEL_BITS-1:0]            alpha0_reg;
    logic [CHANNEL_BITS-1:0]            alpha0_next;
    logic [CHANNEL_BITS-1:0]            factor;
    logic [CHANNEL_BITS-1:0]            alpha_eff;

    // stage 1
    pac_ctl_t                           ctl_reg;
    pac_ctl_t                           ctl_next;
    logic [LANES-1:0]                   sat_reg;
    logic [LANES-1:0]                   sat_next;
    logic [CHANNEL_BITS-1:0]            alpha1_reg;
    logic [CHANNEL_BITS:0]              div_reg;
    logic [CHANNEL_BITS:0]              div_next;
    logic [LANES-1:0][NW-1:0]           num_reg;
    logic [LANES-1:0][NW-1:0]           num_next;

    // Forward: q = (2ca + M) / 2M, with a = M when there is no alpha channel
    // so colors come back unchanged. Reverse: q = (2cM + a) / 2a.
    // In both cases the added term s is half the divisor.
    always_comb
    begin
        alpha_eff = cfg.has_alpha ? alpha : CMAX;
        if (!cfg.direction)
        begin
            factor      = alpha_eff;
            scale_next  = CMAX;
            alpha0_next = alpha_eff;
        end
        else
        begin
            factor      = CMAX;
            scale_next  = alpha;
            alpha0_next = cfg.has_alpha ? alpha : '0;
        end
        for (int l = 0; l < LANES; l++)
        begin
            prod_next[l] = PW'(colour[l]) * PW'(factor);
        end
    end

    always_comb
    begin
        div_next       = {scale_reg, 1'b0};
        ctl_next.valid = valid0_reg;
        ctl_next.zero  = (scale_reg == '0);
        for (int l = 0; l < LANES; l++)
        begin
            num_next[l] = {prod_reg[l], 1'b0} + NW'(scale_reg);
            // quotient would need more than CHANNEL_BITS bits
            sat_next[l] = (num_next[l] >= {div_next, {CHANNEL_BITS{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            ctl_reg    <= '0;
        end
        else
        begin
            valid0_reg <= accept;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        scale_reg  <= scale_next;
        alpha0_reg <= alpha0_next;
        num_reg    <= num_next;
        div_reg    <= div_next;
        sat_reg    <= sat_next;
        alpha1_reg <= alpha0_reg;
    end

    assign ctl_out   = ctl_reg;
    assign sat_out   = sat_reg;
    assign alpha_out = alpha1_reg;
    assign div_out   = div_reg;
    assign num_out   = num_reg;

endmodule

### sv/pac_div_stage.sv
// One restoring division step for all color lanes: quotient bit STEP.
module pac_div_stage #(
    parameter int CHANNEL_BITS = pac_pkg::CHANNEL_BITS_DEFAULT,
    parameter int STEP         = 0
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  pac_pkg::pac_ctl_t                              ctl_in,
    input  logic [pac_pkg::LANES-1:0]                      sat_in,
    input  logic [CHANNEL_BITS-1:0]                        alpha_in,
    input  logic [CHANNEL_BITS:0]                          div_in,
    input  logic [pac_pkg::LANES-1:0][2*CHANNEL_BITS:0]    rem_in,
    input  logic [pac_pkg::LANES-1:0][CHANNEL_BITS-1:0]    quo_in,
    output pac_pkg::pac_ctl_t                              ctl_out,
    output logic [pac_pkg::LANES-1:0]                      sat_out,
    output logic [CHANNEL_BITS-1:0]                        alpha_out,
    output logic [CHANNEL_BITS:0]                          div_out,
    output logic [pac_pkg::LANES-1:0][2*CHANNEL_BITS:0]    rem_out,
    output logic [pac_pkg::LANES-1:0][CHANNEL_BITS-1:0]    quo_out
);
    import pac_pkg::*;

    localparam int NW = 2 * CHANNEL_BITS + 1;

    pac_ctl_t                           ctl_reg;
    logic [LANES-1:0]                   sat_reg;
    logic [CHANNEL_BITS-1:0]            alpha_reg;
    logic [CHANNEL_BITS:0]              div_reg;
    logic [LANES-1:0][NW-1:0]           rem_reg;
    logic [LANES-1:0][NW-1:0]           rem_next;
    logic [LANES-1:0][CHANNEL_BITS-1:0] quo_reg;
    logic [LANES-1:0][CHANNEL_BITS-1:0] quo_next;
    logic [NW-1:0]                      trial;
    logic                               take;

    always_comb
    begin
        trial    = NW'(div_in) << STEP;
        take     = 1'b0;
        rem_next = rem_in;
        quo_next = quo_in;
        for (int l = 0; l < LANES; l++)
        begin
            take        = (rem_in[l] >= trial);
            rem_next[l] = take ? (rem_in[l] - trial) : rem_in[l];
            quo_next[l] = {quo_in[l][CHANNEL_BITS-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        sat_reg   <= sat_in;
        alpha_reg <= alpha_in;
        div_reg   <= div_in;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign ctl_out   = ctl_reg;
    assign sat_out   = sat_reg;
    assign alpha_out = alpha_reg;
    assign div_out   = div_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

### sv/premultiplied_alpha_converter_top.sv
// Premultiplied alpha converter. Takes one pixel per clock whenever start is
// high (busy is never raised) and returns it converted, marked by a one-cycle
// done strobe. The receiver cannot stall: results must be taken in the cycle
// they appear. The result passes through the restoring divider, one quotient
// bit per pipeline stage, preceded by a multiply stage and a numerator stage
// and followed by the output register. Both directions run through the same
// divider, so every rounding is exact. Write direction / has_alpha only while
// no pixel is in flight.
`include "premultiplied_alpha_converter_top_defines.svh"

module premultiplied_alpha_converter_top #(
    parameter int CHANNEL_BITS = pac_pkg::CHANNEL_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [CHANNEL_BITS-1:0]              in_red,
    input  logic [CHANNEL_BITS-1:0]              in_green,
    input  logic [CHANNEL_BITS-1:0]              in_blue,
    input  logic [CHANNEL_BITS-1:0]              in_alpha,
    output logic                                 done,
    output logic [CHANNEL_BITS-1:0]              out_red,
    output logic [CHANNEL_BITS-1:0]              out_green,
    output logic [CHANNEL_BITS-1:0]              out_blue,
    output logic [CHANNEL_BITS-1:0]              out_alpha,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pac_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic                                 cfg_data
);
    import pac_pkg::*;

    localparam int NW      = 2 * CHANNEL_BITS + 1;
    localparam int LATENCY = CHANNEL_BITS + 3;
    localparam logic [CHANNEL_BITS-1:0] CMAX = {CHANNEL_BITS{1'b1}};

    pac_cfg_t                                cfg;
    logic [LANES-1:0][CHANNEL_BITS-1:0]      colour;

    pac_ctl_t                                ctl_pipe   [CHANNEL_BITS+1];
    logic [LANES-1:0]                        sat_pipe   [CHANNEL_BITS+1];
    logic [CHANNEL_BITS-1:0]                 alpha_pipe [CHANNEL_BITS+1];
    logic [CHANNEL_BITS:0]                   div_pipe   [CHANNEL_BITS+1];
    logic [LANES-1:0][NW-1:0]                rem_pipe   [CHANNEL_BITS+1];
    logic [LANES-1:0][CHANNEL_BITS-1:0]      quo_pipe   [CHANNEL_BITS+1];

    logic                                    done_reg;
    logic [LANES-1:0][CHANNEL_BITS-1:0]      out_colour_reg;
    logic [LANES-1:0][CHANNEL_BITS-1:0]      out_colour_next;
    logic [CHANNEL_BITS-1:0]                 out_alpha_reg;

    // fully pipelined, every cycle takes a word
    assign busy   = 1'b0;
    assign colour = {in_blue, in_green, in_red};

    pac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pac_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .cfg       (cfg),
        .colour    (colour),
        .alpha     (in_alpha),
        .ctl_out   (ctl_pipe[0]),
        .sat_out   (sat_pipe[0]),
        .alpha_out (alpha_pipe[0]),
        .div_out   (div_pipe[0]),
        .num_out   (rem_pipe[0])
    );

    assign quo_pipe[0] = '0;

    for (genvar k = 0; k < CHANNEL_BITS; k++)
    begin : g_div
        pac_div_stage #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .STEP         (CHANNEL_BITS - 1 - k)
        ) u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_pipe[k]),
            .sat_in    (sat_pipe[k]),
            .alpha_in  (alpha_pipe[k]),
            .div_in    (div_pipe[k]),
            .rem_in    (rem_pipe[k]),
            .quo_in    (quo_pipe[k]),
            .ctl_out   (ctl_pipe[k+1]),
            .sat_out   (sat_pipe[k+1]),
            .alpha_out (alpha_pipe[k+1]),
            .div_out   (div_pipe[k+1]),
            .rem_out   (rem_pipe[k+1]),
            .quo_out   (quo_pipe[k+1])
        );
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (ctl_pipe[CHANNEL_BITS].zero)
            begin
                out_colour_next[l] = '0;
            end
            else if (sat_pipe[CHANNEL_BITS][l])
            begin
                out_colour_next[l] = CMAX;
            end
            else
            begin
                out_colour_next[l] = quo_pipe[CHANNEL_BITS][l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_pipe[CHANNEL_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_colour_reg <= out_colour_next;
        out_alpha_reg  <= alpha_pipe[CHANNEL_BITS];
    end

    assign done      = done_reg;
    assign out_red   = out_colour_reg[0];
    assign out_green = out_colour_reg[1];
    assign out_blue  = out_colour_reg[2];
    assign out_alpha = out_alpha_reg;

    // every result traces back to a word taken earlier
    `PAC_ASSERT_IMPL(a_done_has_source, clk, rst_n, done, $past(start, LATENCY))
    // unless overflowed or forced black, the divider leaves a proper remainder
    `PAC_ASSERT_IMPL(a_div_remainder, clk, rst_n,
        ctl_pipe[CHANNEL_BITS].valid && !ctl_pipe[CHANNEL_BITS].zero,
        (sat_pipe[CHANNEL_BITS][0] || (rem_pipe[CHANNEL_BITS][0] < NW'(div_pipe[CHANNEL_BITS])))
        && (sat_pipe[CHANNEL_BITS][1] || (rem_pipe[CHANNEL_BITS][1] < NW'(div_pipe[CHANNEL_BITS])))
        && (sat_pipe[CHANNEL_BITS][2] || (rem_pipe[CHANNEL_BITS][2] < NW'(div_pipe[CHANNEL_BITS]))))
    // a forced-black word comes out black
    `PAC_ASSERT_NEXT(a_zero_alpha_black, clk, rst_n,
        ctl_pipe[CHANNEL_BITS].valid && ctl_pipe[CHANNEL_BITS].zero,
        done && (out_red == '0) && (out_green == '0) && (out_blue == '0))

endmodule

### dv/tb_premultiplied_alpha_converter_top.sv
`timescale 1ns / 100ps

module tb_premultiplied_alpha_converter_top;

    import pac_pkg::*;

    localparam int W          = CHANNEL_BITS_DEFAULT;
    localparam int PIX_MAX    = (1 << W) - 1;
    localparam int LATENCY    = W + 3;
    localparam int RAND_SETS  = 8;
    localparam int RAND_ITEMS = 50;

    typedef struct packed {
        logic [W-1:0] red;
        logic [W-1:0] green;
        logic [W-1:0] blue;
        logic [W-1:0] alpha;
    } pixel_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [W-1:0]              in_red;
    logic [W-1:0]              in_green;
    logic [W-1:0]              in_blue;
    logic [W-1:0]              in_alpha;
    logic                      done;
    logic [W-1:0]              out_red;
    logic [W-1:0]              out_green;
    logic [W-1:0]              out_blue;
    logic [W-1:0]              out_alpha;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic                      cfg_data;

    premultiplied_alpha_converter_top #(
        .CHANNEL_BITS(W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .in_red   (in_red),
        .in_green (in_green),
        .in_blue  (in_blue),
        .in_alpha (in_alpha),
        .done     (done),
        .out_red  (out_red),
        .out_green(out_green),
        .out_blue (out_blue),
        .out_alpha(out_alpha),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // pixels waiting to be sent, and converted pixels waiting to come back
    pixel_t      pending_px[$];
    pixel_t      expected_px[$];

    // register copy kept by the predictor
    logic        mode_reverse;
    logic        mode_has_alpha;

    logic        word_taken;
    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_zero_alpha;
    int unsigned n_saturated;
    int unsigned n_cfg_writes;
    pixel_t      drive_px;
    pixel_t      seen_px;
    pixel_t      got_px;
    pixel_t      want_px;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("timeout: %0d pixels still outstanding", expected_px.size());
        $display("FAIL premultiplied_alpha_converter_top");
        $finish;
    end

    // alpha/MAX scaling, rounded half up
    function automatic logic [W-1:0] premul_channel(input int unsigned c, input int unsigned a);
        return W'((2 * c * a + PIX_MAX) / (2 * PIX_MAX));
    endfunction

    // MAX/alpha scaling, rounded half up and clipped; zero alpha gives black
    function automatic logic [W-1:0] unpremul_channel(input int unsigned c,
                                                      input int unsigned a);
        int unsigned q;
        if (a == 0)
            return '0;
        q = (2 * c * PIX_MAX + a) / (2 * a);
        return (q > PIX_MAX) ? W'(PIX_MAX) : W'(q);
    endfunction

    function automatic pixel_t convert_pixel(input pixel_t px, input logic reverse,
                                             input logic has_alpha);
        pixel_t res;
        if (!reverse)
        begin
            if (has_alpha)
            begin
                res.red   = premul_channel(32'(px.red), 32'(px.alpha));
                res.green = premul_channel(32'(px.green), 32'(px.alpha));
                res.blue  = premul_channel(32'(px.blue), 32'(px.alpha));
                res.alpha = px.alpha;
            end
            else
            begin
                res       = px;
                res.alpha = W'(PIX_MAX);
            end
        end
        else
        begin
            res.red   = unpremul_channel(32'(px.red), 32'(px.alpha));
            res.green = unpremul_channel(32'(px.green), 32'(px.alpha));
            res.blue  = unpremul_channel(32'(px.blue), 32'(px.alpha));
            res.alpha = has_alpha ? px.alpha : '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // mostly back to back, short gaps, now and then a long one
    function automatic int unsigned next_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (roll < 4)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !word_taken)
        begin
            // hold the word until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            start    <= 1'b0;
            in_red   <= W'($urandom);
            in_green <= W'($urandom);
            in_blue  <= W'($urandom);
            in_alpha <= W'($urandom);
        end
        else if (pending_px.size() > 0)
        begin
            drive_px = pending_px.pop_front();
            start    <= 1'b1;
            in_red   <= drive_px.red;
            in_green <= drive_px.green;
            in_blue  <= drive_px.blue;
            in_alpha <= drive_px.alpha;
            gap_left = next_gap();
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_cfg_writes++;
                case (cfg_index)
                    REG_DIRECTION: mode_reverse   = cfg_data;
                    REG_HAS_ALPHA: mode_has_alpha = cfg_data;
                    default: ;
                endcase
            end
            if (done)
            begin
                got_px = '{out_red, out_green, out_blue, out_alpha};
                if (expected_px.size() == 0)
                begin
                    report_mismatch("word with nothing pending, red", int'(got_px.red), -1);
                end
                else
                begin
                    want_px = expected_px.pop_front();
                    n_checked++;
                    if (got_px.red !== want_px.red)
                        report_mismatch("out_red", int'(got_px.red), int'(want_px.red));
                    if (got_px.green !== want_px.green)
                        report_mismatch("out_green", int'(got_px.green), int'(want_px.green));
                    if (got_px.blue !== want_px.blue)
                        report_mismatch("out_blue", int'(got_px.blue), int'(want_px.blue));
                    if (got_px.alpha !== want_px.alpha)
                        report_mismatch("out_alpha", int'(got_px.alpha), int'(want_px.alpha));
                end
            end
            word_taken = start && !busy;
            if (word_taken)
            begin
                seen_px = '{in_red, in_green, in_blue, in_alpha};
                expected_px.push_back(convert_pixel(seen_px, mode_reverse, mode_has_alpha));
                if (mode_reverse && seen_px.alpha == 0)
                    n_zero_alpha++;
                if (mode_reverse && (seen_px.red > seen_px.alpha
                                     || seen_px.green > seen_px.alpha
                                     || seen_px.blue > seen_px.alpha))
                    n_saturated++;
            end
        end
    end

    task automatic queue_pixel(input int r, input int g, input int b, input int a);
        pending_px.push_back('{r[W-1:0], g[W-1:0], b[W-1:0], a[W-1:0]});
    endtask

    function automatic pixel_t random_pixel(input logic reverse);
        pixel_t      px;
        int unsigned kind;
        px   = $urandom;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            px.alpha = '0;
        else if (kind == 1)
            px.alpha = W'(PIX_MAX);
        else if (kind == 2)
            px.alpha = W'($urandom_range(1, 4));
        if (kind == 8)
        begin
            px.red   = $urandom_range(0, 1) ? W'(PIX_MAX) : '0;
            px.green = $urandom_range(0, 1) ? W'(PIX_MAX) : '0;
            px.blue  = $urandom_range(0, 1) ? W'(PIX_MAX) : '0;
        end
        else if (reverse && kind != 9)
        begin
            // well-formed premultiplied color: no channel above alpha
            px.red   = W'($urandom_range(0, 32'(px.alpha)));
            px.green = W'($urandom_range(0, 32'(px.alpha)));
            px.blue  = W'($urandom_range(0, 32'(px.alpha)));
        end
        return px;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic reverse, input logic has_alpha);
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_DIRECTION, reverse);
            write_reg(REG_HAS_ALPHA, has_alpha);
        end
        else
        begin
            write_reg(REG_HAS_ALPHA, has_alpha);
            write_reg(REG_DIRECTION, reverse);
        end
    endtask

    // sender holds off until every pixel is back and the pipe is empty
    task automatic drain();
        do
            @(negedge clk);
        while (pending_px.size() > 0 || start || expected_px.size() > 0);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    initial
    begin
        logic rev_sel;
        logic alpha_sel;

        rst_n          = 1'b0;
        start          = 1'b0;
        in_red         = '0;
        in_green       = '0;
        in_blue        = '0;
        in_alpha       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DIRECTION;
        cfg_data       = 1'b0;
        mode_reverse   = 1'b0;
        mode_has_alpha = 1'b1;
        word_taken     = 1'b0;
        gap_left       = 0;
        burst_left     = 0;
        n_errors       = 0;
        n_checked      = 0;
        n_zero_alpha   = 0;
        n_saturated    = 0;
        n_cfg_writes   = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // forward with alpha, reset settings
        queue_pixel(0, 0, 0, 0);
        queue_pixel(255, 255, 255, 255);
        queue_pixel(255, 128, 1, 0);
        queue_pixel(255, 254, 1, 1);
        queue_pixel(1, 2, 3, 128);
        queue_pixel(170, 85, 127, 254);
        drain();

        // reverse with alpha: zero alpha, clipping, exact half rounding
        set_mode(1'b1, 1'b1);
        queue_pixel(200, 255, 1, 0);
        queue_pixel(255, 255, 255, 255);
        queue_pixel(255, 10, 2, 1);
        queue_pixel(1, 1, 1, 2);
        queue_pixel(3, 5, 7, 10);
        queue_pixel(128, 127, 0, 128);
        queue_pixel(0, 0, 0, 1);
        drain();

        // forward without alpha channel: alpha ignored, output alpha full
        set_mode(1'b0, 1'b0);
        queue_pixel(0, 128, 255, 0);
        queue_pixel(255, 0, 1, 37);
        queue_pixel(12, 34, 56, 255);
        drain();

        // reverse without alpha channel: output alpha forced to zero
        set_mode(1'b1, 1'b0);
        queue_pixel(100, 50, 25, 0);
        queue_pixel(200, 100, 50, 200);
        queue_pixel(255, 255, 255, 1);
        queue_pixel(64, 32, 16, 255);
        drain();

        for (int set = 0; set < RAND_SETS; set++)
        begin
            if (set < 4)
            begin
                rev_sel   = (set == 0 || set == 2);
                alpha_sel = (set < 2);
            end
            else
            begin
                rev_sel   = 1'($urandom_range(0, 1));
                alpha_sel = $urandom_range(0, 3) != 0;
            end
            set_mode(rev_sel, alpha_sel);
            for (int n = 0; n < RAND_ITEMS; n++)
                pending_px.push_back(random_pixel(rev_sel));
            drain();
        end

        $display("checked %0d pixels across %0d register writes", n_checked, n_cfg_writes);
        $display("reverse pixels with zero alpha: %0d, with channels above alpha: %0d",
                 n_zero_alpha, n_saturated);
        if (n_errors == 0)
        begin
            $display("PASS premultiplied_alpha_converter_top");
        end
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("FAIL premultiplied_alpha_converter_top");
        end
        $finish;
    end

endmodule
